### hw/rtl/nfd_pkg.sv
// shared types, constants and helper functions for the navigation frame deframer
// used by nav_frame_deframer_unit; no other dependencies

package nfd_pkg;

  localparam int unsigned FIELD_BYTES = 256;
  localparam int unsigned FS_AW       = $clog2(FIELD_BYTES);
  localparam int unsigned HOLD_DEPTH  = 6;
  localparam int unsigned NUM_FIELDS  = 24;

  localparam logic [7:0]  SYNC_RESET  = 8'h57;
  localparam logic [31:0] CMD_RESET   = 32'h0000_0003;
  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [32:0] MIN_FRAME   = 33'd161;

  // result status codes
  localparam logic [1:0] ST_FIELD   = 2'd0;
  localparam logic [1:0] ST_BAD_FMT = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_BAD_CMD = 2'd3;

  // configuration register indexes
  localparam logic CFG_SYNC = 1'b0;
  localparam logic CFG_CMD  = 1'b1;

  localparam logic [4:0] FIELD_UP_VEL = 5'd8;
  localparam logic [4:0] FIELD_LAST   = 5'd23;

  typedef logic [7:0] byte_t;

  // byte-wise crc-32, msb first
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input byte_t b);
    logic [31:0] c;
    c = c_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // 0 marks the illegal width code
  function automatic logic [2:0] seg_width(input logic [1:0] code);
    logic [2:0] w;
    case (code)
      2'd0:    w = 3'd1;
      2'd1:    w = 3'd2;
      2'd2:    w = 3'd4;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic logic [FS_AW-1:0] fld_off(input logic [4:0] idx);
    logic [FS_AW-1:0] o;
    case (idx)
      5'd0:  o = FS_AW'(5);
      5'd1:  o = FS_AW'(9);
      5'd2:  o = FS_AW'(17);
      5'd3:  o = FS_AW'(25);
      5'd4:  o = FS_AW'(33);
      5'd5:  o = FS_AW'(41);
      5'd6:  o = FS_AW'(49);
      5'd7:  o = FS_AW'(57);
      5'd8:  o = FS_AW'(57);
      5'd9:  o = FS_AW'(65);
      5'd10: o = FS_AW'(73);
      5'd11: o = FS_AW'(81);
      5'd12: o = FS_AW'(89);
      5'd13: o = FS_AW'(97);
      5'd14: o = FS_AW'(105);
      5'd15: o = FS_AW'(113);
      5'd16: o = FS_AW'(121);
      5'd17: o = FS_AW'(129);
      5'd18: o = FS_AW'(137);
      5'd19: o = FS_AW'(138);
      5'd20: o = FS_AW'(139);
      5'd21: o = FS_AW'(140);
      5'd22: o = FS_AW'(148);
      default: o = FS_AW'(156);
    endcase
    return o;
  endfunction

  // bytes per field: u32, double or single byte
  function automatic logic [3:0] fld_nb(input logic [4:0] idx);
    logic [3:0] n;
    case (idx)
      5'd0:                   n = 4'd4;
      5'd18, 5'd19, 5'd20, 5'd23: n = 4'd1;
      default:                n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

### hw/rtl/nav_frame_deframer_unit.sv
// navigation frame deframer: sync hunt, header checks, field store, crc and field output
// depends on nfd_pkg

// One received byte per request. Inside a frame body bytes are taken without a stall. Outside a
// frame each byte is followed by the header scan steps (dropping a non-sync byte or giving
// a format status) before the next byte is taken, and an accepted header is then copied
// into the field store one byte per step. At the end of a frame the command bytes and then
// each of the 24 fields are read from the field store one byte a cycle; a good frame's
// drain also waits on any output stall. Results sit in an output register, so a new byte is
// taken while a result still waits. The field store needs no clearing after reset.
module nav_frame_deframer_unit
  import nfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_field_index,
  output logic [63:0] out_field_value,
  output logic        out_last,
  output logic [31:0] out_good_count,
  output logic [31:0] out_format_bad_count,
  output logic [31:0] out_crc_bad_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_HLOAD  = 3'd2;
  localparam logic [2:0] S_GATHER = 3'd3;
  localparam logic [2:0] S_CMDCHK = 3'd4;
  localparam logic [2:0] S_FEMIT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  sync_r;
  logic [31:0] cmd_r;
  logic        body_r, body_nxt;
  logic [32:0] pos_r, pos_nxt;
  logic [32:0] flen_r, flen_nxt;
  logic [5:0]  seg_r, seg_nxt;
  logic [2:0]  hlen_r, hlen_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] tail_r, tail_nxt;
  byte_t       hold_r [HOLD_DEPTH];
  byte_t       hold_nxt [HOLD_DEPTH];
  logic [2:0]  hold_n_r, hold_n_nxt;
  logic [2:0]  hl_i_r, hl_i_nxt;
  logic [31:0] good_r, good_nxt, fmt_r, fmt_nxt, crcc_r, crcc_nxt;

  // gather unit: reads nb bytes from base, one per cycle
  logic [FS_AW-1:0] g_base_r, g_base_nxt;
  logic [3:0]  g_nb_r, g_nb_nxt, g_j_r, g_j_nxt, g_n_r, g_n_nxt;
  logic        g_be_r, g_be_nxt, g_pend_r, g_pend_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  fi_r, fi_nxt;

  byte_t            mem_r [FIELD_BYTES];
  byte_t            mem_q_r;
  logic             mem_we;
  logic [FS_AW-1:0] mem_wa, rd_addr;
  byte_t            mem_wd;

  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [4:0]  oidx_r, oidx_nxt;
  logic [63:0] oval_r, oval_nxt;
  logic [31:0] og_r, og_nxt, of_r, of_nxt, oc_r, oc_nxt;

  logic        in_acc, emit_ok;
  byte_t       info;
  logic [2:0]  lw, aw, cw;
  logic        info_bad;
  logic [2:0]  hlen_c;
  logic [31:0] len_raw;
  logic [32:0] len_c;
  logic [32:0] pos_inc;
  logic [3:0]  cmd_off;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_ok   = !ov_r || !out_stall;

  assign info     = hold_r[1];
  assign lw       = seg_width(info[5:4]);
  assign aw       = seg_width(info[3:2]);
  assign cw       = seg_width(info[1:0]);
  assign info_bad = (info[7] != ^info[6:0]) || lw == 3'd0 || aw == 3'd0 || cw == 3'd0;
  assign hlen_c   = 3'd2 + lw;
  assign pos_inc  = pos_r + 33'd1;
  assign cmd_off  = 4'd2 + {1'b0, seg_width(seg_r[5:4])} + {1'b0, seg_width(seg_r[3:2])};

  always_comb begin
    case (lw)
      3'd1:    len_raw = {24'h0, hold_r[2]};
      3'd2:    len_raw = {16'h0, hold_r[2], hold_r[3]};
      default: len_raw = {hold_r[2], hold_r[3], hold_r[4], hold_r[5]};
    endcase
    len_c = {1'b0, len_raw} + 33'(hlen_c);
  end

  always_comb begin
    state_nxt  = state_r;
    body_nxt   = body_r;
    pos_nxt    = pos_r;
    flen_nxt   = flen_r;
    seg_nxt    = seg_r;
    hlen_nxt   = hlen_r;
    crc_nxt    = crc_r;
    tail_nxt   = tail_r;
    hold_nxt   = hold_r;
    hold_n_nxt = hold_n_r;
    hl_i_nxt   = hl_i_r;
    good_nxt   = good_r;
    fmt_nxt    = fmt_r;
    crcc_nxt   = crcc_r;
    g_base_nxt = g_base_r;
    g_nb_nxt   = g_nb_r;
    g_j_nxt    = g_j_r;
    g_n_nxt    = g_n_r;
    g_be_nxt   = g_be_r;
    g_pend_nxt = 1'b0;
    acc_nxt    = acc_r;
    fi_nxt     = fi_r;
    mem_we     = 1'b0;
    mem_wa     = pos_r[FS_AW-1:0];
    mem_wd     = in_data_byte;
    rd_addr    = g_base_r + FS_AW'(g_j_r);
    ov_nxt     = ov_r && out_stall;
    ost_nxt    = ost_r;
    oidx_nxt   = oidx_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    og_nxt     = og_r;
    of_nxt     = of_r;
    oc_nxt     = oc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (body_r) begin
            mem_we = (pos_r < 33'(FIELD_BYTES));
            if (pos_r + 33'd4 < flen_r) begin
              crc_nxt = crc_byte(crc_r, in_data_byte);
            end else begin
              tail_nxt = {tail_r[23:0], in_data_byte};
            end
            pos_nxt = pos_inc;
            if (pos_inc >= flen_r) begin
              body_nxt   = 1'b0;
              g_base_nxt = FS_AW'(cmd_off);
              g_nb_nxt   = {1'b0, seg_width(seg_r[1:0])};
              g_j_nxt    = 4'd0;
              g_n_nxt    = 4'd0;
              g_be_nxt   = 1'b1;
              acc_nxt    = '0;
              state_nxt  = S_GATHER;
            end
          end else begin
            if (hold_n_r == 3'(HOLD_DEPTH)) begin
              for (int i = 0; i < HOLD_DEPTH - 1; i++) hold_nxt[i] = hold_r[i+1];
              hold_nxt[HOLD_DEPTH-1] = in_data_byte;
            end else begin
              hold_nxt[hold_n_r] = in_data_byte;
              hold_n_nxt = hold_n_r + 3'd1;
            end
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hold_n_r != 3'd0 && hold_r[0] != sync_r) begin
          for (int i = 0; i < HOLD_DEPTH - 1; i++) hold_nxt[i] = hold_r[i+1];
          hold_n_nxt = hold_n_r - 3'd1;
        end else if (hold_n_r < 3'd3) begin
          state_nxt = S_IDLE;
        end else if (!info_bad && hold_n_r < hlen_c) begin
          state_nxt = S_IDLE;
        end else if (info_bad || len_c < MIN_FRAME) begin
          if (emit_ok) begin
            fmt_nxt = fmt_r + 32'd1;
            ov_nxt = 1'b1; ost_nxt = ST_BAD_FMT; oidx_nxt = '0; oval_nxt = '0;
            olast_nxt = 1'b1; og_nxt = good_r; of_nxt = fmt_nxt; oc_nxt = crcc_r;
            for (int i = 0; i < HOLD_DEPTH - 1; i++) hold_nxt[i] = hold_r[i+1];
            hold_n_nxt = hold_n_r - 3'd1;
          end
        end else begin
          flen_nxt  = len_c;
          seg_nxt   = info[5:0];
          hlen_nxt  = hlen_c;
          crc_nxt   = CRC_INIT;
          tail_nxt  = '0;
          hl_i_nxt  = 3'd0;
          state_nxt = S_HLOAD;
        end
      end
      S_HLOAD: begin
        mem_we = 1'b1;
        mem_wa = FS_AW'(hl_i_r);
        mem_wd = hold_r[hl_i_r];
        if (hl_i_r != 3'd0) crc_nxt = crc_byte(crc_r, hold_r[hl_i_r]);
        if (hl_i_r == hlen_r - 3'd1) begin
          body_nxt   = 1'b1;
          pos_nxt    = 33'(hlen_r);
          hold_n_nxt = 3'd0;
          state_nxt  = S_IDLE;
        end else begin
          hl_i_nxt = hl_i_r + 3'd1;
        end
      end
      S_GATHER: begin
        if (g_j_r < g_nb_r) begin
          g_j_nxt    = g_j_r + 4'd1;
          g_pend_nxt = 1'b1;
        end
        if (g_pend_r) begin
          g_n_nxt = g_n_r + 4'd1;
          if (g_be_r) acc_nxt = {acc_r[55:0], mem_q_r};
          else acc_nxt[8*g_n_r[2:0] +: 8] = mem_q_r;
        end
        if (g_n_r == g_nb_r) state_nxt = g_be_r ? S_CMDCHK : S_FEMIT;
      end
      S_CMDCHK: begin
        if (acc_r[31:0] != cmd_r) begin
          if (emit_ok) begin
            fmt_nxt = fmt_r + 32'd1;
            ov_nxt = 1'b1; ost_nxt = ST_BAD_CMD; oidx_nxt = '0; oval_nxt = '0;
            olast_nxt = 1'b1; og_nxt = good_r; of_nxt = fmt_nxt; oc_nxt = crcc_r;
            state_nxt = S_IDLE;
          end
        end else if (crc_r != tail_r) begin
          if (emit_ok) begin
            crcc_nxt = crcc_r + 32'd1;
            ov_nxt = 1'b1; ost_nxt = ST_BAD_CRC; oidx_nxt = '0; oval_nxt = '0;
            olast_nxt = 1'b1; og_nxt = good_r; of_nxt = fmt_r; oc_nxt = crcc_nxt;
            state_nxt = S_IDLE;
          end
        end else begin
          good_nxt   = good_r + 32'd1;
          fi_nxt     = 5'd0;
          g_base_nxt = fld_off(5'd0);
          g_nb_nxt   = fld_nb(5'd0);
          g_j_nxt    = 4'd0;
          g_n_nxt    = 4'd0;
          g_be_nxt   = 1'b0;
          acc_nxt    = '0;
          state_nxt  = S_GATHER;
        end
      end
      S_FEMIT: begin
        if (emit_ok) begin
          ov_nxt = 1'b1; ost_nxt = ST_FIELD; oidx_nxt = fi_r;
          oval_nxt = acc_r ^ {(fi_r == FIELD_UP_VEL), 63'h0};
          olast_nxt = (fi_r == FIELD_LAST);
          og_nxt = good_r; of_nxt = fmt_r; oc_nxt = crcc_r;
          if (fi_r == FIELD_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            fi_nxt     = fi_r + 5'd1;
            g_base_nxt = fld_off(fi_r + 5'd1);
            g_nb_nxt   = fld_nb(fi_r + 5'd1);
            g_j_nxt    = 4'd0;
            g_n_nxt    = 4'd0;
            acc_nxt    = '0;
            state_nxt  = S_GATHER;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    mem_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    flen_r   <= flen_nxt;
    seg_r    <= seg_nxt;
    hlen_r   <= hlen_nxt;
    tail_r   <= tail_nxt;
    hold_r   <= hold_nxt;
    hl_i_r   <= hl_i_nxt;
    g_base_r <= g_base_nxt;
    g_nb_r   <= g_nb_nxt;
    g_j_r    <= g_j_nxt;
    g_n_r    <= g_n_nxt;
    g_be_r   <= g_be_nxt;
    acc_r    <= acc_nxt;
    fi_r     <= fi_nxt;
    ost_r    <= ost_nxt;
    oidx_r   <= oidx_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
    og_r     <= og_nxt;
    of_r     <= of_nxt;
    oc_r     <= oc_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      body_r   <= 1'b0;
      crc_r    <= CRC_INIT;
      hold_n_r <= 3'd0;
      good_r   <= '0;
      fmt_r    <= '0;
      crcc_r   <= '0;
      g_pend_r <= 1'b0;
      ov_r     <= 1'b0;
      sync_r   <= SYNC_RESET;
      cmd_r    <= CMD_RESET;
    end else begin
      state_r  <= state_nxt;
      body_r   <= body_nxt;
      crc_r    <= crc_nxt;
      hold_n_r <= hold_n_nxt;
      good_r   <= good_nxt;
      fmt_r    <= fmt_nxt;
      crcc_r   <= crcc_nxt;
      g_pend_r <= g_pend_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SYNC) sync_r <= cfg_data[7:0];
        else cmd_r <= cfg_data;
      end
    end
  end

  assign out_valid            = ov_r;
  assign out_status           = ost_r;
  assign out_field_index      = oidx_r;
  assign out_field_value      = oval_r;
  assign out_last             = olast_r;
  assign out_good_count       = og_r;
  assign out_format_bad_count = of_r;
  assign out_crc_bad_count    = oc_r;

`ifndef SYNTHESIS
  // the header buffer is always emptied when a frame body starts
  a_body_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    body_r |-> hold_n_r == 3'd0)
    else $error("header bytes held inside a frame body");

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_n_r <= 3'(HOLD_DEPTH))
    else $error("header buffer overflow");

  // captured bytes never outrun issued reads
  a_gather_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GATHER |-> g_n_r <= g_j_r && g_j_r <= g_nb_r)
    else $error("gather read sequencing broken");

  // a rejection result is a lone last result with empty payload
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r != ST_FIELD |-> olast_r && oidx_r == 5'd0 && oval_r == 64'h0)
    else $error("malformed status result");
`endif

endmodule
